>>> hdl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// shared constants, register codes and config type for the mixdown resampler
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int DEF_MAX_CHANNELS  = 8;
    localparam int DEF_SAMPLE_BITS   = 24;
    localparam int DEF_FRACTION_BITS = 16;

    // fixed field and register widths
    localparam int NUM_CH_FIELDS  = 8;
    localparam int CH_COUNT_BITS  = 4;
    localparam int IN_RATE_BITS   = 19;
    localparam int OUT_RATE_BITS  = 16;
    localparam int POS_BITS       = 19;
    localparam int DIVISOR_BITS   = 16;
    localparam int LEAD_BITS      = 10;
    localparam int RESULT_CNT_BITS = 4;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;
    localparam int REG_IDX_BITS   = 2;

    localparam logic [RESULT_CNT_BITS-1:0] MAX_RESULTS = 4'd12;

    // register index codes
    localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_IN_RATE       = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_OUT_RATE      = 2'd2;

    // reset values and legal ranges
    localparam logic [CH_COUNT_BITS-1:0] CH_COUNT_RESET = 4'd1;
    localparam logic [IN_RATE_BITS-1:0]  IN_RATE_RESET  = 19'd16000;
    localparam logic [OUT_RATE_BITS-1:0] OUT_RATE_RESET = 16'd16000;
    localparam logic [IN_RATE_BITS-1:0]  IN_RATE_MIN    = 19'd8000;
    localparam logic [IN_RATE_BITS-1:0]  IN_RATE_MAX    = 19'd384000;
    localparam logic [OUT_RATE_BITS-1:0] OUT_RATE_MIN   = 16'd8000;
    localparam logic [OUT_RATE_BITS-1:0] OUT_RATE_MAX   = 16'd48000;

    localparam logic signed [LEAD_BITS-1:0] LEAD_FLOOR = -10'sd1;

    // clamped configuration as the datapath uses it
    typedef struct packed {
        logic [CH_COUNT_BITS-1:0] nch;
        logic [IN_RATE_BITS-1:0]  rin;
        logic [OUT_RATE_BITS-1:0] rout;
    } mlr_cfg_t;

endpackage

>>> hdl/mlr_stream_if.sv
// ----------------------------------------------------------------------------
// mlr stream interfaces
// frame request channel and result request channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface mlr_frame_if
    import mlr_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] ch0_sample;
    logic signed [SAMPLE_BITS-1:0] ch1_sample;
    logic signed [SAMPLE_BITS-1:0] ch2_sample;
    logic signed [SAMPLE_BITS-1:0] ch3_sample;
    logic signed [SAMPLE_BITS-1:0] ch4_sample;
    logic signed [SAMPLE_BITS-1:0] ch5_sample;
    logic signed [SAMPLE_BITS-1:0] ch6_sample;
    logic signed [SAMPLE_BITS-1:0] ch7_sample;
    logic                          last_frame;

    modport source (
        output valid, ch0_sample, ch1_sample, ch2_sample, ch3_sample,
               ch4_sample, ch5_sample, ch6_sample, ch7_sample, last_frame,
        input  ready
    );

    modport sink (
        input  valid, ch0_sample, ch1_sample, ch2_sample, ch3_sample,
               ch4_sample, ch5_sample, ch6_sample, ch7_sample, last_frame,
        output ready
    );
endinterface

interface mlr_result_if
    import mlr_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          last_in_run;
    logic                          stream_end;

    modport source (
        output valid, out_sample, last_in_run, stream_end,
        input  ready
    );

    modport sink (
        input  valid, out_sample, last_in_run, stream_end,
        output ready
    );
endinterface

>>> hdl/mlr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mlr_cfg_regs
// apb register file: channel count and both rates, with clamped view
// ----------------------------------------------------------------------------
module mlr_cfg_regs
    import mlr_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output mlr_cfg_t                 cfg
);

    localparam logic [CH_COUNT_BITS-1:0] NCH_MAX = CH_COUNT_BITS'(MAX_CHANNELS);

    logic [CH_COUNT_BITS-1:0] ch_count_reg;
    logic [IN_RATE_BITS-1:0]  in_rate_reg;
    logic [OUT_RATE_BITS-1:0] out_rate_reg;
    logic [REG_IDX_BITS-1:0]  reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-REG_IDX_BITS];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_count_reg <= CH_COUNT_RESET;
            in_rate_reg  <= IN_RATE_RESET;
            out_rate_reg <= OUT_RATE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CHANNEL_COUNT: ch_count_reg <= pwdata[CH_COUNT_BITS-1:0];
                REG_IN_RATE:       in_rate_reg  <= pwdata[IN_RATE_BITS-1:0];
                REG_OUT_RATE:      out_rate_reg <= pwdata[OUT_RATE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CHANNEL_COUNT: prdata = APB_DATA_BITS'(ch_count_reg);
            REG_IN_RATE:       prdata = APB_DATA_BITS'(in_rate_reg);
            REG_OUT_RATE:      prdata = APB_DATA_BITS'(out_rate_reg);
            default:           prdata = '0;
        endcase
    end

    // saturate into the supported ranges
    always_comb
    begin
        if (ch_count_reg == '0)
            cfg.nch = CH_COUNT_BITS'(1);
        else if (ch_count_reg > NCH_MAX)
            cfg.nch = NCH_MAX;
        else
            cfg.nch = ch_count_reg;

        if (in_rate_reg < IN_RATE_MIN)
            cfg.rin = IN_RATE_MIN;
        else if (in_rate_reg > IN_RATE_MAX)
            cfg.rin = IN_RATE_MAX;
        else
            cfg.rin = in_rate_reg;

        if (out_rate_reg < OUT_RATE_MIN)
            cfg.rout = OUT_RATE_MIN;
        else if (out_rate_reg > OUT_RATE_MAX)
            cfg.rout = OUT_RATE_MAX;
        else
            cfg.rout = out_rate_reg;
    end

endmodule

>>> hdl/mlr_div.sv
// ----------------------------------------------------------------------------
// mlr_div
// shared restoring divider, one quotient bit per cycle, msb-first dividend
// ----------------------------------------------------------------------------
module mlr_div
    import mlr_pkg::*;
#(
    parameter int DW = 27,
    parameter int CW = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [CW-1:0]           count,
    input  logic [DW-1:0]           dividend,
    input  logic [DIVISOR_BITS-1:0] divisor,
    input  logic [DIVISOR_BITS-1:0] rem_init,
    output logic                    done,
    output logic [DW-1:0]           quotient,
    output logic [DIVISOR_BITS-1:0] remainder
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [DW-1:0]           shr_reg;
    logic [DW-1:0]           quo_reg;
    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [DIVISOR_BITS-1:0] dvs_reg;
    logic [DIVISOR_BITS:0]   trial;
    logic                    fits;
    logic [DIVISOR_BITS-1:0] rem_next;

    // remainder stays below the divisor, so the trial fits one extra bit
    assign trial    = {rem_reg, shr_reg[DW-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? DIVISOR_BITS'(trial - {1'b0, dvs_reg})
                           : DIVISOR_BITS'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= count;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shr_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= rem_init;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            shr_reg <= shr_reg << 1;
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/mlr_interp.sv
// ----------------------------------------------------------------------------
// mlr_interp
// two-stage linear interpolator: a + (b - a) * t, floored to sample width
// ----------------------------------------------------------------------------
module mlr_interp
    import mlr_pkg::*;
#(
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic signed [SAMPLE_BITS-1:0] b,
    input  logic [FRACTION_BITS-1:0]      t,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] value
);

    localparam int PW = SAMPLE_BITS + FRACTION_BITS + 2;

    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRACTION_BITS:0] t_s;
    logic signed [PW-1:0]          prod_next;
    logic signed [PW-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [PW-1:0]          acc;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          stage_reg;
    logic                          done_reg;

    assign diff      = (SAMPLE_BITS+1)'(b) - (SAMPLE_BITS+1)'(a);
    assign t_s       = $signed({1'b0, t});
    assign prod_next = PW'(diff) * PW'(t_s);

    // a*2^F + (b-a)*t, the arithmetic shift gives the floor
    assign acc = (PW'(a_reg) <<< FRACTION_BITS) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
        if (stage_reg)
            value_reg <= acc[FRACTION_BITS+SAMPLE_BITS-1:FRACTION_BITS];
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

>>> hdl/mixdown_linear_resampler.sv
// ----------------------------------------------------------------------------
// mixdown_linear_resampler
// sequencing: each frame runs on the single bit-serial divider (mono average,
// then per result one position and one weight division, each one bit a
// cycle); a result taken without interpolation skips the interpolator, and a
// frame that hits twelve results skips the closing weight division
// throughput: one frame at a time, the frame channel is not ready while busy
// reset: rst_n is asynchronous, active low; clears sequencer, stream state
// and output valid, config registers return to 1 channel, 16000 / 16000 hz
// ----------------------------------------------------------------------------
module mixdown_linear_resampler
    import mlr_pkg::*;
#(
    parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    mlr_frame_if.sink                frame,
    mlr_result_if.source             result
);

    // sum of up to MAX_CHANNELS samples
    localparam int SW = SAMPLE_BITS + $clog2(MAX_CHANNELS);
    // divider word: wide enough for the sum, the position and the weight
    localparam int DW0 = (SW > POS_BITS) ? SW : POS_BITS;
    localparam int DW  = (DW0 > FRACTION_BITS) ? DW0 : FRACTION_BITS;
    localparam int CW  = $clog2(DW + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_MONO_GO     = 4'd1;
    localparam logic [3:0] S_MONO_WAIT   = 4'd2;
    localparam logic [3:0] S_POS_GO      = 4'd3;
    localparam logic [3:0] S_POS_WAIT    = 4'd4;
    localparam logic [3:0] S_T_GO        = 4'd5;
    localparam logic [3:0] S_T_WAIT      = 4'd6;
    localparam logic [3:0] S_DECIDE      = 4'd7;
    localparam logic [3:0] S_INTERP_WAIT = 4'd8;
    localparam logic [3:0] S_PUSH        = 4'd9;
    localparam logic [3:0] S_FLUSH       = 4'd10;

    mlr_cfg_t cfg;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // per-request working registers
    logic signed [SW-1:0]          sum_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic [FRACTION_BITS-1:0]      t_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic [RESULT_CNT_BITS-1:0]    n_reg;

    // stream state carried between frames
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic                          have_prev_reg;
    logic [POS_BITS-1:0]           np_reg;
    logic signed [LEAD_BITS-1:0]   lead_reg;

    // one result held back until we know whether it closes the run
    logic                          pend_valid_reg;
    logic signed [SAMPLE_BITS-1:0] pend_reg;

    // output register, parts the result channel from the sequencer
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_last_reg;
    logic                          out_end_reg;

    logic signed [SAMPLE_BITS-1:0] ch_arr [NUM_CH_FIELDS];
    logic signed [SW-1:0]          sum_comb;
    logic [SW-1:0]                 sum_mag;
    logic [SW-1:0]                 mono_mag;
    logic [SW-1:0]                 mono_val;

    logic                          accept;
    logic                          out_free;
    logic                          out_load;
    logic                          step_done;

    logic                          div_start;
    logic [CW-1:0]                 div_count;
    logic [DW-1:0]                 div_dividend;
    logic [DIVISOR_BITS-1:0]       div_divisor;
    logic [DIVISOR_BITS-1:0]       div_rem_init;
    logic                          div_done;
    logic [DW-1:0]                 div_quo;
    logic [DIVISOR_BITS-1:0]       div_rem;

    logic                          ip_start;
    logic                          ip_done;
    logic signed [SAMPLE_BITS-1:0] ip_value;
    logic signed [SAMPLE_BITS-1:0] ip_a;

    logic signed [LEAD_BITS-1:0]   lead_dec;
    logic                          emit_interp;
    logic                          emit_direct;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    mlr_cfg_regs #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_mlr_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // mixdown sum, only the active channels contribute
    // ------------------------------------------------------------------
    assign ch_arr[0] = frame.ch0_sample;
    assign ch_arr[1] = frame.ch1_sample;
    assign ch_arr[2] = frame.ch2_sample;
    assign ch_arr[3] = frame.ch3_sample;
    assign ch_arr[4] = frame.ch4_sample;
    assign ch_arr[5] = frame.ch5_sample;
    assign ch_arr[6] = frame.ch6_sample;
    assign ch_arr[7] = frame.ch7_sample;

    always_comb
    begin
        sum_comb = '0;
        for (int c = 0; c < NUM_CH_FIELDS; c++)
        begin
            if (c < int'(cfg.nch))
                sum_comb = sum_comb + SW'(ch_arr[c]);
        end
    end

    // magnitude for the divider, sign restored afterwards (truncate toward zero)
    assign sum_mag  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign mono_mag = div_quo[SW-1:0];
    assign mono_val = sum_reg[SW-1] ? SW'(~mono_mag + SW'(1)) : mono_mag;

    // ------------------------------------------------------------------
    // shared divider: mono average, position renormalize, weight
    // ------------------------------------------------------------------
    always_comb
    begin
        div_start    = 1'b0;
        div_count    = CW'(POS_BITS);
        div_dividend = DW'(np_reg) << (DW - POS_BITS);
        div_divisor  = cfg.rout;
        div_rem_init = '0;
        case (state_reg)
            S_MONO_GO:
            begin
                div_start    = 1'b1;
                div_count    = CW'(SW);
                div_dividend = DW'(sum_mag) << (DW - SW);
                div_divisor  = DIVISOR_BITS'(cfg.nch);
            end
            S_POS_GO:
            begin
                div_start = 1'b1;
            end
            S_T_GO:
            begin
                // remainder already below out_rate, shift in the fraction bits
                div_start    = 1'b1;
                div_count    = CW'(FRACTION_BITS);
                div_dividend = '0;
                div_rem_init = np_reg[DIVISOR_BITS-1:0];
            end
            default: ;
        endcase
    end

    mlr_div #(
        .DW (DW),
        .CW (CW)
    ) u_mlr_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .count     (div_count),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .rem_init  (div_rem_init),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ------------------------------------------------------------------
    // interpolator between the previous and the current mono sample
    // ------------------------------------------------------------------
    assign ip_a        = have_prev_reg ? prev_reg : '0;
    assign emit_interp = lead_reg < 0;
    assign emit_direct = (lead_reg == 0) && ((t_reg == '0) || last_reg);
    assign ip_start    = (state_reg == S_DECIDE) && emit_interp;

    mlr_interp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mlr_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ip_start),
        .a     (ip_a),
        .b     (cur_reg),
        .t     (t_reg),
        .done  (ip_done),
        .value (ip_value)
    );

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign frame.ready = (state_reg == S_IDLE);
    assign accept      = frame.valid && frame.ready;
    assign out_free    = !out_valid_reg || result.ready;

    // a held result moves out when a newer one arrives or the run closes
    assign out_load  = pend_valid_reg && out_free
                       && ((state_reg == S_PUSH) || (state_reg == S_FLUSH));
    // push or flush may proceed once the held slot can be vacated
    assign step_done = !pend_valid_reg || out_free;

    // lead drops by one per frame but never below one step behind
    assign lead_dec = (lead_reg - LEAD_BITS'(1) < LEAD_FLOOR) ? LEAD_FLOOR
                                                              : lead_reg - LEAD_BITS'(1);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:        if (accept) state_next = S_MONO_GO;
            S_MONO_GO:     state_next = S_MONO_WAIT;
            S_MONO_WAIT:   if (div_done) state_next = S_POS_GO;
            S_POS_GO:      state_next = S_POS_WAIT;
            S_POS_WAIT:
            begin
                if (div_done)
                    state_next = (n_reg == MAX_RESULTS) ? S_FLUSH : S_T_GO;
            end
            S_T_GO:        state_next = S_T_WAIT;
            S_T_WAIT:      if (div_done) state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (emit_interp)
                    state_next = S_INTERP_WAIT;
                else if (emit_direct)
                    state_next = S_PUSH;
                else
                    state_next = S_FLUSH;
            end
            S_INTERP_WAIT: if (ip_done) state_next = S_PUSH;
            S_PUSH:        if (step_done) state_next = S_POS_GO;
            S_FLUSH:       if (step_done) state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            np_reg         <= '0;
            lead_reg       <= '0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        n_reg <= '0;
                end
                S_POS_WAIT:
                begin
                    if (div_done)
                    begin
                        lead_reg <= lead_reg + $signed({1'b0, div_quo[LEAD_BITS-2:0]});
                        np_reg   <= POS_BITS'(div_rem);
                    end
                end
                S_PUSH:
                begin
                    if (step_done)
                    begin
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + RESULT_CNT_BITS'(1);
                        np_reg         <= np_reg + POS_BITS'(cfg.rin);
                    end
                end
                S_FLUSH:
                begin
                    if (step_done)
                    begin
                        pend_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            // stream closed, next frame starts a fresh one
                            prev_reg      <= '0;
                            have_prev_reg <= 1'b0;
                            np_reg        <= '0;
                            lead_reg      <= '0;
                        end
                        else
                        begin
                            prev_reg      <= cur_reg;
                            have_prev_reg <= 1'b1;
                            lead_reg      <= lead_dec;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= sum_comb;
            last_reg <= frame.last_frame;
        end
        if ((state_reg == S_MONO_WAIT) && div_done)
            cur_reg <= mono_val[SAMPLE_BITS-1:0];
        if ((state_reg == S_T_WAIT) && div_done)
            t_reg <= div_quo[FRACTION_BITS-1:0];
        if ((state_reg == S_DECIDE) && emit_direct)
            val_reg <= cur_reg;
        if ((state_reg == S_INTERP_WAIT) && ip_done)
            val_reg <= ip_value;
        if ((state_reg == S_PUSH) && step_done)
            pend_reg <= val_reg;
        if (out_load)
        begin
            out_sample_reg <= pend_reg;
            out_last_reg   <= (state_reg == S_FLUSH);
            out_end_reg    <= (state_reg == S_FLUSH) && last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_sample  = out_sample_reg;
    assign result.last_in_run = out_last_reg;
    assign result.stream_end  = out_end_reg;

endmodule

>>> hdl/mlr_checker.sv
// ----------------------------------------------------------------------------
// mlr_checker
// port-level assertions for the mixdown resampler, bound to the top level
// ----------------------------------------------------------------------------
module mlr_checker
    import mlr_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [SAMPLE_BITS-1:0]   out_sample,
    input logic                     last_in_run,
    input logic                     stream_end,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic                     pready,
    input logic [APB_ADDR_BITS-1:0] paddr,
    input logic [APB_DATA_BITS-1:0] pwdata,
    input logic [APB_DATA_BITS-1:0] prdata
);

    logic [REG_IDX_BITS-1:0] reg_idx;

    assign reg_idx = paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-REG_IDX_BITS];

    // end of stream always closes the run of its frame
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_end) |-> last_in_run)
        else $error("stream_end without last_in_run");

    // one frame at a time: an accepted request blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("frame accepted back to back");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)
                                       && $stable(last_in_run) && $stable(stream_end)))
        else $error("stalled result changed");

    // channel count write reads back on the same address
    a_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (reg_idx == REG_CHANNEL_COUNT))
        ##1 (reg_idx == REG_CHANNEL_COUNT)
        |-> (prdata[CH_COUNT_BITS-1:0] == $past(pwdata[CH_COUNT_BITS-1:0])))
        else $error("channel count readback mismatch");

endmodule

bind mixdown_linear_resampler mlr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mlr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (frame.valid),
    .in_ready    (frame.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_sample  (result.out_sample),
    .last_in_run (result.last_in_run),
    .stream_end  (result.stream_end),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

>>> tb/sv/mixdown_linear_resampler_tb.sv
// ----------------------------------------------------------------------------
// mixdown_linear_resampler_tb
// self-checking bench for the channel mixdown and linear interpolation
// resampler: a scoreboard class predicts every result from the accepted frame
// requests and the register settings, plain tasks drive the apb port and the
// frame channel while the result channel stalls at random
// ----------------------------------------------------------------------------
module mixdown_linear_resampler_tb;
    import mlr_pkg::*;

    localparam int SB  = DEF_SAMPLE_BITS;
    localparam int FB  = DEF_FRACTION_BITS;
    localparam int NCH = NUM_CH_FIELDS;

    // the worst frame finishes well within this, so this covers any frame
    localparam int SETTLE_CYCLES  = 1000;
    // long receiver hold-off, enough for the frame channel to back up
    localparam int HOLD_CYCLES    = 2500;
    // cycles with no handshake of any kind before the run is declared hung
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LINES   = 40;
    localparam int PHASE_ITEMS    = 34;

    localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct packed {
        logic [NCH-1:0][SB-1:0] ch;
        logic                   last_frame;
    } frame_t;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 last_in_run;
        logic                 stream_end;
    } result_t;

    // ------------------------------------------------------------------------
    // scoreboard: predictor state, register copy and expected result queue
    // ------------------------------------------------------------------------
    class resample_scoreboard;
        logic [CH_COUNT_BITS-1:0] ch_count;
        logic [IN_RATE_BITS-1:0]  in_rate;
        logic [OUT_RATE_BITS-1:0] out_rate;
        longint                   prev_mono;
        bit                       have_prev;
        longint unsigned          next_position;
        longint                   pos_lead;
        result_t                  expected_q[$];
        int                       errors;
        int                       frames_seen;
        int                       results_seen;

        function new();
            ch_count     = CH_COUNT_RESET;
            in_rate      = IN_RATE_RESET;
            out_rate     = OUT_RATE_RESET;
            errors       = 0;
            frames_seen  = 0;
            results_seen = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            prev_mono     = 0;
            have_prev     = 1'b0;
            next_position = 0;
            pos_lead      = 0;
        endfunction

        function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
            case (idx)
                REG_CHANNEL_COUNT: ch_count = value[CH_COUNT_BITS-1:0];
                REG_IN_RATE:       in_rate  = value[IN_RATE_BITS-1:0];
                REG_OUT_RATE:      out_rate = value[OUT_RATE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // weighted pair of neighbours, floored
        function longint blend(longint a, longint b, longint t);
            longint acc;
            acc = a * ((longint'(1) << FB) - t) + b * t;
            return acc >>> FB;
        endfunction

        function void note_frame(frame_t f);
            int unsigned     nch;
            longint unsigned rin;
            longint unsigned rout;
            longint          sum;
            longint          cur;
            longint          t;
            longint          vals[$];
            result_t         r;
            nch  = (ch_count == 0) ? 1 : ((ch_count > NCH) ? NCH : ch_count);
            rin  = (in_rate < IN_RATE_MIN) ? IN_RATE_MIN :
                   ((in_rate > IN_RATE_MAX) ? IN_RATE_MAX : in_rate);
            rout = (out_rate < OUT_RATE_MIN) ? OUT_RATE_MIN :
                   ((out_rate > OUT_RATE_MAX) ? OUT_RATE_MAX : out_rate);
            sum = 0;
            for (int c = 0; c < nch; c++)
                sum += longint'($signed(f.ch[c]));
            // signed divide truncates toward zero
            cur = sum / longint'(nch);
            // renormalize against the current output rate
            pos_lead      += longint'(next_position / rout);
            next_position  = next_position % rout;
            while (vals.size() < MAX_RESULTS)
            begin
                t = longint'((next_position << FB) / rout);
                if (pos_lead < 0)
                    vals.push_back(blend(have_prev ? prev_mono : 0, cur, t));
                else if (pos_lead == 0 && (t == 0 || f.last_frame))
                    vals.push_back(cur);
                else
                    break;
                next_position += rin;
                pos_lead      += longint'(next_position / rout);
                next_position  = next_position % rout;
            end
            foreach (vals[i])
            begin
                r.sample      = vals[i][SB-1:0];
                r.last_in_run = (i == vals.size() - 1);
                r.stream_end  = r.last_in_run && f.last_frame;
                expected_q.push_back(r);
            end
            if (f.last_frame)
                clear_stream();
            else
            begin
                prev_mono = cur;
                have_prev = 1'b1;
                pos_lead  = (pos_lead - 1 < -1) ? -1 : pos_lead - 1;
            end
            frames_seen++;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LINES)
                $display("mismatch: %s", msg);
        endtask

        task check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d with nothing expected", got.sample));
                return;
            end
            want = expected_q.pop_front();
            if (got.sample !== want.sample)
                report($sformatf("result %0d: out_sample %0d, expected %0d",
                                 results_seen, got.sample, want.sample));
            if (got.last_in_run !== want.last_in_run)
                report($sformatf("result %0d: last_in_run %0b, expected %0b",
                                 results_seen, got.last_in_run, want.last_in_run));
            if (got.stream_end !== want.stream_end)
                report($sformatf("result %0d: stream_end %0b, expected %0b",
                                 results_seen, got.stream_end, want.stream_end));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, buses and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    mlr_frame_if  frame_bus ();
    mlr_result_if result_bus ();

    resample_scoreboard sb = new();

    // idle odds in percent for each side, set per phase by the main sequence
    int tx_idle_pct;
    int rx_idle_pct;
    // hold-off handshake between the main sequence and the receiver process
    int hold_requests;
    int holds_served;
    int hold_left;
    int settings_used;

    always #4 clk = ~clk;

    mixdown_linear_resampler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .frame   (frame_bus),
        .result  (result_bus)
    );

    // ------------------------------------------------------------------------
    // monitor and watchdog: everything sampled at the rising edge
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin : monitor
        frame_t  seen_frame;
        result_t seen_result;
        if (rst_n)
        begin
            // frame first so a same-edge result never overtakes its own frame
            if (frame_bus.valid && frame_bus.ready)
            begin
                seen_frame.ch[0]      = frame_bus.ch0_sample;
                seen_frame.ch[1]      = frame_bus.ch1_sample;
                seen_frame.ch[2]      = frame_bus.ch2_sample;
                seen_frame.ch[3]      = frame_bus.ch3_sample;
                seen_frame.ch[4]      = frame_bus.ch4_sample;
                seen_frame.ch[5]      = frame_bus.ch5_sample;
                seen_frame.ch[6]      = frame_bus.ch6_sample;
                seen_frame.ch[7]      = frame_bus.ch7_sample;
                seen_frame.last_frame = frame_bus.last_frame;
                sb.note_frame(seen_frame);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                seen_result.sample      = result_bus.out_sample;
                seen_result.last_in_run = result_bus.last_in_run;
                seen_result.stream_end  = result_bus.stream_end;
                sb.check_result(seen_result);
            end
            if ((frame_bus.valid && frame_bus.ready) ||
                (result_bus.valid && result_bus.ready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("[mixdown_linear_resampler] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        holds_served = 0;
        hold_left    = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks: each starts and ends just after a falling edge with no
    // drive yet made in that step
    // ------------------------------------------------------------------------

    // register write, then a read back of the same register
    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
        logic [APB_DATA_BITS-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        // read setup follows straight on
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (got !== value)
            sb.report($sformatf("register %0d reads %0d, written %0d", idx, got, value));
    endtask

    task automatic write_config(input logic [31:0] cc, input logic [31:0] rin,
                                input logic [31:0] rout);
        apb_write(REG_CHANNEL_COUNT, cc);
        apb_write(REG_IN_RATE, rin);
        apb_write(REG_OUT_RATE, rout);
        settings_used++;
    endtask

    // random gap, then hold the frame until the block takes it
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(negedge clk);
        end
        frame_bus.ch0_sample <= f.ch[0];
        frame_bus.ch1_sample <= f.ch[1];
        frame_bus.ch2_sample <= f.ch[2];
        frame_bus.ch3_sample <= f.ch[3];
        frame_bus.ch4_sample <= f.ch[4];
        frame_bus.ch5_sample <= f.ch[5];
        frame_bus.ch6_sample <= f.ch[6];
        frame_bus.ch7_sample <= f.ch[7];
        frame_bus.last_frame <= f.last_frame;
        frame_bus.valid      <= 1'b1;
        @(posedge clk);
        while (!frame_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain every expected result, then give a frame with no result time to
    // finish before the registers move
    task automatic settle();
        frame_bus.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic frame_t flat_frame(logic [SB-1:0] value, logic last);
        frame_t f;
        for (int c = 0; c < NCH; c++)
            f.ch[c] = value;
        f.last_frame = last;
        return f;
    endfunction

    // samples lean on the corners now and then
    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic frame_t rand_frame();
        frame_t f;
        for (int c = 0; c < NCH; c++)
            f.ch[c] = rand_sample();
        // streams of a couple dozen frames on average
        f.last_frame = ($urandom_range(23) == 0);
        return f;
    endfunction

    task automatic run_frames(input int count);
        repeat (count) send_frame(rand_frame());
    endtask

    task automatic random_config();
        logic [31:0] cc;
        logic [31:0] rin;
        logic [31:0] rout;
        cc = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
        case ($urandom_range(8))
            0:       rin = 8000;
            1:       rin = 16000;
            2:       rin = 22050;
            3:       rin = 44100;
            4:       rin = 48000;
            5:       rin = 96000;
            6:       rin = 384000;
            default: rin = $urandom_range(19'h7FFFF);
        endcase
        case ($urandom_range(8))
            0:       rout = 8000;
            1:       rout = 16000;
            2:       rout = 22050;
            3:       rout = 44100;
            4:       rout = 48000;
            5:       rout = 0;
            6:       rout = 16'hFFFF;
            default: rout = $urandom_range(16'hFFFF);
        endcase
        write_config(cc, rin, rout);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        frame_t f;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_pct   = 7;
        rx_idle_pct   = 67;
        hold_requests = 0;
        settings_used = 0;
        frame_bus.valid      = 1'b0;
        frame_bus.ch0_sample = '0;
        frame_bus.ch1_sample = '0;
        frame_bus.ch2_sample = '0;
        frame_bus.ch3_sample = '0;
        frame_bus.ch4_sample = '0;
        frame_bus.ch5_sample = '0;
        frame_bus.ch6_sample = '0;
        frame_bus.ch7_sample = '0;
        frame_bus.last_frame = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all eight channels, equal rates pass the mono average straight through
        write_config(8, 16000, 16000);
        send_frame(flat_frame(S_MAX, 1'b0));
        send_frame(flat_frame(S_MIN, 1'b0));
        // small negative sums must truncate toward zero, not floor
        f = flat_frame('0, 1'b0);
        f.ch[0] = SB'(-1);
        send_frame(f);
        f.ch[0] = SB'(-9);
        send_frame(f);
        for (int c = 0; c < NCH; c++)
            f.ch[c] = c[0] ? S_MIN : S_MAX;
        send_frame(f);
        send_frame(rand_frame());

        // rate change in mid stream, no final frame before it; channel count
        // zero acts as one, in_rate zero saturates to the low end, 6x upsample
        settle();
        write_config(0, 0, 32'(OUT_RATE_MAX));
        send_frame(flat_frame(S_MAX, 1'b0));
        send_frame(flat_frame(S_MIN, 1'b0));
        send_frame(flat_frame(S_MAX, 1'b0));
        send_frame(flat_frame('0, 1'b0));
        send_frame(flat_frame(S_MIN, 1'b1));

        // counts and rates above range saturate; 8x downsample, and the final
        // frame lands between output positions so it yields nothing
        settle();
        write_config(15, 32'h7FFFF, 32'hFFFF);
        repeat (10) send_frame(rand_frame());
        f = rand_frame();
        f.last_frame = 1'b1;
        send_frame(f);

        // random streams under three idle patterns, several settings each
        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 7 : ((mode == 1) ? 67 : 0);
            rx_idle_pct = (mode == 0) ? 67 : ((mode == 1) ? 7 : 0);
            for (int k = 0; k < 4; k++)
            begin
                settle();
                if (mode == 2 && k == 1)
                begin
                    // 3x upsample so results pile up while the receiver backs off
                    write_config(2, 16000, 48000);
                    hold_requests++;
                end
                else
                    random_config();
                run_frames(PHASE_ITEMS);
            end
        end

        settle();
        $display("run covered %0d frames and %0d results over %0d register settings",
                 sb.frames_seen, sb.results_seen, settings_used);
        $display("with sender and receiver stalls, one long hold-off, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("[mixdown_linear_resampler] OK");
        else
            $display("[mixdown_linear_resampler] ERROR");
        $finish;
    end

endmodule
